// ===== rtl/triangle_index_to_edge_lines_macros.svh =====
// assertion macros shared by the triangle index to edge lines rtl
// no dependencies; included by modules that carry assertions
`ifndef TRIANGLE_INDEX_TO_EDGE_LINES_MACROS_SVH
`define TRIANGLE_INDEX_TO_EDGE_LINES_MACROS_SVH

// same-cycle implication, disabled during reset
`define TIEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tiel assertion failed");

// next-cycle implication, disabled during reset
`define TIEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tiel assertion failed");

`endif

// ===== rtl/tiel_pkg.sv =====
// shared types, constants and helper functions for the triangle edge lines block
// no dependencies
`timescale 1ns / 1ps

package tiel_pkg;

    // port field width and default index width
    localparam int FIELD_W         = 32;
    localparam int INDEX_WIDTH_DEF = 32;

    // beats per triangle: a, b, b, c, c, a
    localparam int TRI_BEATS = 6;
    localparam int STEP_W    = $clog2(TRI_BEATS);

    // position tracking
    localparam int           PHASE_W   = 4;
    localparam logic [3:0]   PHASE_TOP = 4'd11;
    localparam int           WARM_W    = 3;
    localparam logic [2:0]   WARM_MAX  = 3'd7;

    // connectivity selector
    typedef enum logic [2:0] {
        MODE_LIST       = 3'd0,
        MODE_STRIP      = 3'd1,
        MODE_FAN        = 3'd2,
        MODE_ADJ_LIST   = 3'd3,
        MODE_ADJ_STRIP  = 3'd4,
        MODE_LINES      = 3'd5,
        MODE_DROP       = 3'd6
    } mode_t;

    // job hand-off from assembler to emitter
    typedef struct packed {
        logic load;
        logic pass;
    } job_ctrl_t;

    // position modulo six, phase is always below twelve
    function automatic logic [2:0] phase_mod6(input logic [3:0] ph);
        logic [3:0] r;
        r = (ph >= 4'd6) ? ph - 4'd6 : ph;
        return r[2:0];
    endfunction

    // position modulo three
    function automatic logic [1:0] phase_mod3(input logic [3:0] ph);
        logic [2:0] m;
        m = phase_mod6(ph);
        m = (m >= 3'd3) ? m - 3'd3 : m;
        return m[1:0];
    endfunction

endpackage

// ===== rtl/tiel_vertex_if.sv =====
// vertex index stream channel: valid, ready, index and buffer start flag
// depends on tiel_pkg
`timescale 1ns / 1ps

interface tiel_vertex_if;
    logic                           valid;
    logic                           ready;
    logic [tiel_pkg::FIELD_W-1:0]   vertex_index;
    logic                           buffer_start;

    modport source (output valid, output vertex_index, output buffer_start, input ready);
    modport sink   (input valid, input vertex_index, input buffer_start, output ready);
endinterface

// ===== rtl/tiel_line_if.sv =====
// line index stream channel: valid, ready, endpoint index and run last flag
// depends on tiel_pkg
`timescale 1ns / 1ps

interface tiel_line_if;
    logic                           valid;
    logic                           ready;
    logic [tiel_pkg::FIELD_W-1:0]   line_index;
    logic                           run_last;

    modport source (output valid, output line_index, output run_last, input ready);
    modport sink   (input valid, input line_index, input run_last, output ready);
endinterface

// ===== rtl/tiel_assembler.sv =====
// input register, mode register and triangle assembly state; hands at most one job per item
// depends on tiel_pkg, tiel_vertex_if and the macros header
`timescale 1ns / 1ps
`include "triangle_index_to_edge_lines_macros.svh"

module tiel_assembler #(
    parameter int INDEX_WIDTH = tiel_pkg::INDEX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_wdata,
    tiel_vertex_if.sink                 vertices,
    input  logic                        emit_free,
    output tiel_pkg::job_ctrl_t         job,
    output logic [INDEX_WIDTH-1:0]      job_a,
    output logic [INDEX_WIDTH-1:0]      job_b,
    output logic [INDEX_WIDTH-1:0]      job_c
);

    localparam int PW = tiel_pkg::PHASE_W;
    localparam int WW = tiel_pkg::WARM_W;

    // input register
    logic                       in_valid_reg;
    logic [INDEX_WIDTH-1:0]     in_vidx_reg;
    logic                       in_start_reg;

    // assembly state
    tiel_pkg::mode_t            mode_reg;
    logic [INDEX_WIDTH-1:0]     hist_reg [3];
    logic [INDEX_WIDTH-1:0]     hist_next [3];
    logic [INDEX_WIDTH-1:0]     anchor_reg;
    logic [INDEX_WIDTH-1:0]     anchor_next;
    logic [PW-1:0]              phase_reg;
    logic [PW-1:0]              phase_next;
    logic [WW-1:0]              warm_reg;
    logic [WW-1:0]              warm_next;

    logic                       take;
    logic [PW-1:0]              ph;
    logic [WW-1:0]              w;
    logic [INDEX_WIDTH-1:0]     v;
    logic                       emit;

    // an item moves on when the emitter can take its job
    assign take           = in_valid_reg && emit_free;
    assign vertices.ready = !in_valid_reg || emit_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (vertices.ready)
        begin
            in_valid_reg <= vertices.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vertices.valid && vertices.ready)
        begin
            in_vidx_reg  <= vertices.vertex_index[INDEX_WIDTH-1:0];
            in_start_reg <= vertices.buffer_start;
        end
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tiel_pkg::MODE_LIST;
        end
        else if (cfg_we)
        begin
            mode_reg <= tiel_pkg::mode_t'(cfg_wdata);
        end
    end

    // assembly logic for the item in the input register
    always_comb
    begin
        v         = in_vidx_reg;
        ph        = in_start_reg ? '0 : phase_reg;
        w         = in_start_reg ? '0 : warm_reg;
        hist_next = hist_reg;
        anchor_next = (w == '0) ? v : anchor_reg;
        emit      = 1'b0;
        job.pass  = 1'b0;
        job_a     = hist_reg[0];
        job_b     = hist_reg[1];
        job_c     = v;

        case (mode_reg)
            tiel_pkg::MODE_LIST:
            begin
                case (tiel_pkg::phase_mod3(ph))
                    2'd0:    hist_next[0] = v;
                    2'd1:    hist_next[1] = v;
                    default: emit = 1'b1;
                endcase
            end
            tiel_pkg::MODE_STRIP:
            begin
                emit = (w >= WW'(2));
                if (ph[0])
                begin
                    job_a = hist_reg[1];
                    job_b = hist_reg[0];
                end
                hist_next[0] = hist_reg[1];
                hist_next[1] = v;
            end
            tiel_pkg::MODE_FAN:
            begin
                emit         = (w >= WW'(2));
                job_a        = anchor_next;
                hist_next[1] = v;
            end
            tiel_pkg::MODE_ADJ_LIST:
            begin
                job_c = hist_reg[2];
                case (tiel_pkg::phase_mod6(ph))
                    3'd0:    hist_next[0] = v;
                    3'd2:    hist_next[1] = v;
                    3'd4:    hist_next[2] = v;
                    3'd5:    emit = 1'b1;
                    default: ;
                endcase
            end
            tiel_pkg::MODE_ADJ_STRIP:
            begin
                job_c = hist_reg[2];
                if (!ph[0])
                begin
                    hist_next[0] = hist_reg[1];
                    hist_next[1] = hist_reg[2];
                    hist_next[2] = v;
                end
                else
                begin
                    emit = (w >= WW'(5));
                    if (ph[1])
                    begin
                        job_a = hist_reg[1];
                        job_b = hist_reg[0];
                    end
                end
            end
            tiel_pkg::MODE_LINES:
            begin
                emit     = 1'b1;
                job.pass = 1'b1;
                job_a    = v;
            end
            default: ;
        endcase

        job.load   = take && emit;
        phase_next = (ph == tiel_pkg::PHASE_TOP) ? '0 : ph + PW'(1);
        warm_next  = (w == tiel_pkg::WARM_MAX) ? w : w + WW'(1);
    end

    // state update on each consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
            anchor_reg  <= '0;
            phase_reg   <= '0;
            warm_reg    <= '0;
        end
        else if (take)
        begin
            hist_reg   <= hist_next;
            anchor_reg <= anchor_next;
            phase_reg  <= phase_next;
            warm_reg   <= warm_next;
        end
    end

    // checks
    `TIEL_ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, phase_reg <= tiel_pkg::PHASE_TOP)
    `TIEL_ASSERT_IMPL(a_load_needs_item, clk, rst_n, job.load, in_valid_reg && emit_free)
    `TIEL_ASSERT_NEXT(a_warm_saturates, clk, rst_n,
        take && !in_start_reg && warm_reg == tiel_pkg::WARM_MAX,
        warm_reg == tiel_pkg::WARM_MAX)

endmodule

// ===== rtl/tiel_emitter.sv =====
// result register and beat sequencer: six beats per triangle, one per passthrough
// depends on tiel_pkg, tiel_line_if and the macros header
`timescale 1ns / 1ps
`include "triangle_index_to_edge_lines_macros.svh"

module tiel_emitter #(
    parameter int INDEX_WIDTH = tiel_pkg::INDEX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tiel_pkg::job_ctrl_t         job,
    input  logic [INDEX_WIDTH-1:0]      job_a,
    input  logic [INDEX_WIDTH-1:0]      job_b,
    input  logic [INDEX_WIDTH-1:0]      job_c,
    tiel_line_if.source                 lines,
    output logic                        emit_free
);

    localparam int                        FW        = tiel_pkg::FIELD_W;
    localparam int                        SW        = tiel_pkg::STEP_W;
    localparam logic [SW-1:0]             LAST_STEP = SW'(tiel_pkg::TRI_BEATS - 1);

    logic                       valid_reg;
    logic                       pass_reg;
    logic [SW-1:0]              step_reg;
    logic [INDEX_WIDTH-1:0]     a_reg;
    logic [INDEX_WIDTH-1:0]     b_reg;
    logic [INDEX_WIDTH-1:0]     c_reg;
    logic [INDEX_WIDTH-1:0]     sel;
    logic                       beat;
    logic                       last;

    assign last      = pass_reg || (step_reg == LAST_STEP);
    assign beat      = valid_reg && lines.ready;
    assign emit_free = !valid_reg || (beat && last);

    // endpoint order a, b, b, c, c, a
    always_comb
    begin
        case (step_reg)
            3'd1, 3'd2: sel = b_reg;
            3'd3, 3'd4: sel = c_reg;
            default:    sel = a_reg;
        endcase
    end

    assign lines.valid      = valid_reg;
    assign lines.line_index = FW'(sel);
    assign lines.run_last   = last;

    // job control and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pass_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else if (job.load)
        begin
            valid_reg <= 1'b1;
            pass_reg  <= job.pass;
            step_reg  <= '0;
        end
        else if (beat)
        begin
            valid_reg <= !last;
            step_reg  <= step_reg + SW'(1);
        end
    end

    // job payload
    always_ff @(posedge clk)
    begin
        if (job.load)
        begin
            a_reg <= job_a;
            b_reg <= job_b;
            c_reg <= job_c;
        end
    end

    // checks
    `TIEL_ASSERT_IMPL(a_load_when_free, clk, rst_n, job.load, emit_free)
    `TIEL_ASSERT_IMPL(a_step_range, clk, rst_n, valid_reg, step_reg <= LAST_STEP)
    `TIEL_ASSERT_NEXT(a_done_drops_valid, clk, rst_n,
        beat && last && !job.load, !valid_reg)

endmodule

// ===== rtl/triangle_index_to_edge_lines.sv =====
// Triangle index stream to wireframe edge lines. Each accepted vertex index is
// held in an input register, then assembled combinationally against the selected
// connectivity; a completed triangle (a, b, c) is loaded into the result register
// and leaves as six line endpoints a, b, b, c, c, a, one beat per cycle while
// lines.ready is high, run_last on the sixth; the emitter's step counter sets the
// order. A passthrough index leaves as a single beat with run_last, and an index
// that completes nothing is consumed without a beat once the emitter is free.
// One new index is taken into the input register while the previous job is still
// draining. An accepted index passes the input register and the result register
// before lines.valid rises. assembly_mode is written through cfg_we/cfg_wdata;
// the user must do so only while idle, as the block itself does not enforce it.
// depends on tiel_pkg, tiel_vertex_if, tiel_line_if, tiel_assembler, tiel_emitter
`timescale 1ns / 1ps

module triangle_index_to_edge_lines #(
    parameter int INDEX_WIDTH = tiel_pkg::INDEX_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_wdata,
    tiel_vertex_if.sink     vertices,
    tiel_line_if.source     lines
);

    tiel_pkg::job_ctrl_t        job;
    logic [INDEX_WIDTH-1:0]     job_a;
    logic [INDEX_WIDTH-1:0]     job_b;
    logic [INDEX_WIDTH-1:0]     job_c;
    logic                       emit_free;

    // triangle assembly
    tiel_assembler #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vertices  (vertices),
        .emit_free (emit_free),
        .job       (job),
        .job_a     (job_a),
        .job_b     (job_b),
        .job_c     (job_c)
    );

    // edge beat output
    tiel_emitter #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_a     (job_a),
        .job_b     (job_b),
        .job_c     (job_c),
        .lines     (lines),
        .emit_free (emit_free)
    );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for triangle_index_to_edge_lines: vertex beats in, edge line beats out
// depends on tiel_pkg, tiel_vertex_if, tiel_line_if and the triangle_index_to_edge_lines rtl
`timescale 1ns / 1ps

module testbench;

    localparam int              INDEX_W        = tiel_pkg::INDEX_WIDTH_DEF;
    localparam logic [63:0]     MASK_WIDE      = (64'd1 << INDEX_W) - 64'd1;
    localparam logic [31:0]     IDX_MASK       = MASK_WIDE[31:0];
    localparam logic [2:0]      MODE_SEL_SEVEN = 3'd7;
    localparam int              SETTLE_CYCLES  = 8;
    localparam int              DRAIN_LIMIT    = 5000;
    localparam longint          TIMEOUT_NS     = 3_000_000;

    // one expected output beat
    typedef struct packed {
        logic [31:0] line_index;
        logic        run_last;
    } line_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_wdata;

    tiel_vertex_if vertices ();
    tiel_line_if   lines ();

    triangle_index_to_edge_lines #(
        .INDEX_WIDTH (INDEX_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vertices  (vertices),
        .lines     (lines)
    );

    // assembler state as the block should hold it
    logic [2:0]  mode_sel;
    logic [31:0] held [3];
    logic [31:0] anchor_idx;
    logic [3:0]  phase;
    logic [2:0]  warm;

    line_beat_t  pending_lines [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int vertices_sent;
    int beats_checked;
    int mode_writes;

    // clock
    always #4 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
    begin
        lines.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // append one expected beat at the tail
    function automatic void queue_expected(input line_beat_t item);
        pending_lines = {pending_lines, item};
    endfunction

    // queue the six endpoints of edges a-b, b-c, c-a
    function automatic void push_triangle(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        logic [31:0] seq [6];
        seq = '{a, b, b, c, c, a};
        for (int k = 0; k < tiel_pkg::TRI_BEATS; k++)
            queue_expected(line_beat_t'{line_index: seq[k], run_last: (k == 5)});
    endfunction

    // expected line beats for one accepted vertex
    function automatic void assemble_vertex(input logic [31:0] raw, input logic start);
        logic [31:0] v;
        logic [3:0]  ph;
        logic [2:0]  w;
        v = raw & IDX_MASK;
        if (start)
        begin
            phase = '0;
            warm  = '0;
        end
        ph = phase;
        w  = warm;
        if (w == 3'd0)
            anchor_idx = v;
        case (mode_sel)
            tiel_pkg::MODE_LIST:
            begin
                if (ph % 3 == 0)
                    held[0] = v;
                else if (ph % 3 == 1)
                    held[1] = v;
                else
                    push_triangle(held[0], held[1], v);
            end
            tiel_pkg::MODE_STRIP:
            begin
                if (w >= 3'd2)
                begin
                    if (!ph[0])
                        push_triangle(held[0], held[1], v);
                    else
                        push_triangle(held[1], held[0], v);
                end
                held[0] = held[1];
                held[1] = v;
            end
            tiel_pkg::MODE_FAN:
            begin
                if (w >= 3'd2)
                    push_triangle(anchor_idx, held[1], v);
                held[1] = v;
            end
            tiel_pkg::MODE_ADJ_LIST:
            begin
                case (ph % 6)
                    0: held[0] = v;
                    2: held[1] = v;
                    4: held[2] = v;
                    5: push_triangle(held[0], held[1], held[2]);
                    default: ;
                endcase
            end
            tiel_pkg::MODE_ADJ_STRIP:
            begin
                if (!ph[0])
                begin
                    held[0] = held[1];
                    held[1] = held[2];
                    held[2] = v;
                end
                else if (w >= 3'd5)
                begin
                    if (ph % 4 == 1)
                        push_triangle(held[0], held[1], held[2]);
                    else
                        push_triangle(held[1], held[0], held[2]);
                end
            end
            tiel_pkg::MODE_LINES:
                queue_expected(line_beat_t'{line_index: v, run_last: 1'b1});
            default: ;
        endcase
        phase = (ph == tiel_pkg::PHASE_TOP) ? 4'd0 : ph + 4'd1;
        warm  = (w < tiel_pkg::WARM_MAX) ? w + 3'd1 : tiel_pkg::WARM_MAX;
    endfunction

    // index values weighted toward the extremes
    function automatic logic [31:0] random_index();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // one vertex beat, with sender idle cycles ahead of it
    task automatic send_vertex(input logic [31:0] idx, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vertices.valid <= 1'b0;
            @(posedge clk);
        end
        vertices.valid        <= 1'b1;
        vertices.vertex_index <= idx;
        vertices.buffer_start <= start;
        @(posedge clk);
        while (!vertices.ready)
            @(posedge clk);
        assemble_vertex(idx, start);
        vertices_sent++;
    endtask

    // stop sending and wait for every expected beat, then let the block settle
    task automatic drain_lines();
        int waited;
        vertices.valid <= 1'b0;
        waited = 0;
        while (pending_lines.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_lines.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected beats never came", pending_lines.size()));
            pending_lines.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only once the block is idle
    task automatic write_mode(input logic [2:0] sel);
        drain_lines();
        cfg_we    <= 1'b1;
        cfg_wdata <= sel;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_sel = sel;
        mode_writes++;
    endtask

    // compare each output beat with the oldest expectation
    always @(posedge clk)
    begin : line_check
        line_beat_t want;
        if (rst_n && lines.valid && lines.ready)
        begin
            beats_checked++;
            if (pending_lines.size() == 0)
                report_mismatch($sformatf("unexpected beat index %h", lines.line_index));
            else
            begin
                want = pending_lines.pop_front();
                if (lines.line_index !== want.line_index)
                    report_mismatch($sformatf("line_index %h, want %h",
                                              lines.line_index, want.line_index));
                if (lines.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              lines.run_last, want.run_last));
            end
        end
    end

    // list mode from reset, stream never marked with a buffer start
    task automatic test_reset_stream();
        send_vertex(32'h0000_0000, 1'b0);
        send_vertex(32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h8000_0001, 1'b0);
    endtask

    task automatic test_lines_passthrough();
        write_mode(tiel_pkg::MODE_LINES);
        send_vertex(32'hFFFF_FFFF, 1'b1);
        send_vertex(32'h0000_0000, 1'b0);
    endtask

    // too short a buffer, then a strip with an even and an odd triangle
    task automatic test_strip_short_buffer();
        write_mode(tiel_pkg::MODE_STRIP);
        send_vertex($urandom, 1'b1);
        send_vertex($urandom, 1'b0);
        send_vertex($urandom, 1'b1);
        for (int i = 0; i < 3; i++)
            send_vertex($urandom, 1'b0);
    endtask

    // fan buffer, then a mode switch that keeps counting inside the buffer
    task automatic test_fan_mode_switch();
        write_mode(tiel_pkg::MODE_FAN);
        send_vertex($urandom, 1'b1);
        for (int i = 0; i < 3; i++)
            send_vertex($urandom, 1'b0);
        write_mode(tiel_pkg::MODE_ADJ_STRIP);
        send_vertex($urandom, 1'b0);
        send_vertex($urandom, 1'b0);
    endtask

    // drop mode and the unused selector both swallow their beats
    task automatic test_drop_selectors();
        write_mode(tiel_pkg::MODE_DROP);
        send_vertex($urandom, 1'b0);
        write_mode(MODE_SEL_SEVEN);
        send_vertex($urandom, 1'b0);
    endtask

    task automatic test_adjacency_list();
        write_mode(tiel_pkg::MODE_ADJ_LIST);
        send_vertex($urandom, 1'b1);
        for (int i = 0; i < 5; i++)
            send_vertex($urandom, 1'b0);
    endtask

    // random buffers, mostly whole groups for the chosen mode
    task automatic test_random_buffers(input int send_pct, input int recv_pct, input int quota);
        int         counted;
        int         pick;
        int         nbuf;
        int         len;
        bit         paused;
        bit         fresh;
        logic [2:0] sel;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted = 0;
        paused  = 1'b0;
        while (counted < quota)
        begin
            pick = $urandom_range(19);
            if (pick < 15)
                sel = 3'(pick % 5);
            else if (pick < 17)
                sel = tiel_pkg::MODE_LINES;
            else if (pick < 19)
                sel = tiel_pkg::MODE_DROP;
            else
                sel = MODE_SEL_SEVEN;
            write_mode(sel);
            nbuf = $urandom_range(1, 3);
            for (int b = 0; b < nbuf; b++)
            begin
                case (sel)
                    tiel_pkg::MODE_LIST:      len = 3 * $urandom_range(1, 4);
                    tiel_pkg::MODE_STRIP,
                    tiel_pkg::MODE_FAN:       len = $urandom_range(3, 12);
                    tiel_pkg::MODE_ADJ_LIST:  len = 6 * $urandom_range(1, 2);
                    tiel_pkg::MODE_ADJ_STRIP: len = 6 + 2 * $urandom_range(0, 4);
                    default:                  len = $urandom_range(1, 6);
                endcase
                // broken buffers and buffers that run on without a start mark
                if ($urandom_range(99) < 15)
                    len = $urandom_range(1, 14);
                fresh = ($urandom_range(9) != 0);
                for (int i = 0; i < len; i++)
                begin
                    // hold off mid-buffer until every beat has drained
                    if (i == len / 2 && (!paused || $urandom_range(7) == 0))
                    begin
                        drain_lines();
                        paused = 1'b1;
                    end
                    send_vertex(random_index(), (i == 0) && fresh);
                    counted++;
                end
            end
        end
    endtask

    // timeout
    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = tiel_pkg::MODE_LIST;
        vertices.valid        = 1'b0;
        vertices.vertex_index = '0;
        vertices.buffer_start = 1'b0;
        mode_sel              = tiel_pkg::MODE_LIST;
        held                  = '{default: '0};
        anchor_idx            = '0;
        phase                 = '0;
        warm                  = '0;
        mismatches            = 0;
        vertices_sent         = 0;
        beats_checked         = 0;
        mode_writes           = 0;
        send_idle_pct         = 33;
        recv_idle_pct         = 48;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_stream();
        test_lines_passthrough();
        test_strip_short_buffer();
        test_fan_mode_switch();
        test_drop_selectors();
        test_adjacency_list();

        test_random_buffers(33, 48, 60);
        test_random_buffers(48, 33, 60);
        test_random_buffers(0, 0, 55);

        drain_lines();
        $display("run covered %0d vertices and %0d line beats across %0d mode writes",
                 vertices_sent, beats_checked, mode_writes);
        $display("all assembly modes, short and broken buffers, and mid-buffer mode switches");
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tiel_pkg.sv
rtl/tiel_vertex_if.sv
rtl/tiel_line_if.sv
rtl/tiel_assembler.sv
rtl/tiel_emitter.sv
rtl/triangle_index_to_edge_lines.sv
verif/testbench.sv
